>>> src/mexp_pkg.sv
// shared constants and types for the modular exponentiation block
package mexp_pkg;

    // default operand width of exponent, modulus and datapath
    localparam int OPERAND_BITS_DEF = 62;

    // fixed field widths of the stream payloads
    localparam int BASE_BITS  = 63;
    localparam int POWER_BITS = 62;
    localparam int S_TDATA_W  = ((BASE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((POWER_BITS + 7) / 8) * 8;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 1'b1;

    // register reset values, masked to the operand width where used
    localparam logic [63:0] EXPONENT_RESET = 64'd65537;
    localparam logic [63:0] MODULUS_RESET  = 64'd2;

    // control from the sequencer to the modular multiplier
    typedef struct packed {
        logic start;
    } t_mm_ctrl;

    // status from the modular multiplier to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_mm_stat;

endpackage

>>> src/mexp_modmul.sv
// shift-add-reduce modular multiplier, one multiplier bit per cycle
module mexp_modmul #(
    parameter int OPND_W = mexp_pkg::OPERAND_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mexp_pkg::t_mm_ctrl i_ctrl,
    input  logic [OPND_W-1:0] i_x,
    input  logic [OPND_W-1:0] i_y,
    input  logic [OPND_W-1:0] i_m,
    output mexp_pkg::t_mm_stat o_stat,
    output logic [OPND_W-1:0] o_result
);
    import mexp_pkg::*;

    logic [OPND_W-1:0] r_x, n_x;
    logic [OPND_W-1:0] r_y, n_y;
    logic [OPND_W-1:0] r_acc, n_acc;
    logic              r_busy, n_busy;
    logic              r_done, n_done;

    logic [OPND_W:0] acc_sum;
    logic [OPND_W:0] x_dbl;
    logic [OPND_W:0] m_ext;

    // add and double, each brought back below the modulus
    assign m_ext   = {1'b0, i_m};
    assign acc_sum = {1'b0, r_acc} + {1'b0, r_x};
    assign x_dbl   = {r_x, 1'b0};

    // step sequencing
    always_comb begin
        n_x    = r_x;
        n_y    = r_y;
        n_acc  = r_acc;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_ctrl.start && !r_busy) begin
            n_x    = i_x;
            n_y    = i_y;
            n_acc  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_y == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                if (r_y[0]) begin
                    n_acc = (acc_sum >= m_ext) ? OPND_W'(acc_sum - m_ext)
                                               : acc_sum[OPND_W-1:0];
                end
                n_x = (x_dbl >= m_ext) ? OPND_W'(x_dbl - m_ext) : x_dbl[OPND_W-1:0];
                n_y = r_y >> 1;
            end
        end
    end

    // control state under reset, operands free running
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_x   <= n_x;
        r_y   <= n_y;
        r_acc <= n_acc;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_result    = r_acc;

endmodule

>>> src/modular_exponentiation_top.sv
// modular exponentiation top level: sequencer, base reduction and stream ports
// a modulus below two skips the base reduction and the multiplier and gives a power of zero
// throughput: one word at a time, set by the single shared shift-add modular multiplier
// the base is first reduced one bit per cycle over its 63 bits
// reset: synchronous active low; exponent resets to 65537, modulus to 2, block idle
module modular_exponentiation_top #(
    parameter int OPERAND_BITS = mexp_pkg::OPERAND_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [mexp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [OPERAND_BITS-1:0]            i_cfg_data,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [mexp_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // [62:0] base, [63] pad
    // output stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [mexp_pkg::M_TDATA_W-1:0]     m_axis_tdata   // [61:0] power, [63:62] zero
);
    import mexp_pkg::*;

    localparam int CNT_W = $clog2(BASE_BITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_BIT,
        S_MULP,
        S_SQ,
        S_MULS,
        S_DONE
    } t_state;

    t_state                  r_state, n_state;
    logic [OPERAND_BITS-1:0] r_exp_cfg, r_mod_cfg;
    logic [OPERAND_BITS-1:0] r_e, n_e;
    logic [OPERAND_BITS-1:0] r_m, n_m;
    logic [OPERAND_BITS-1:0] r_b, n_b;
    logic [OPERAND_BITS-1:0] r_prod, n_prod;
    logic [BASE_BITS-1:0]    r_mag, n_mag;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic                    r_out_valid, n_out_valid;
    logic [OPERAND_BITS-1:0] r_out_power, n_out_power;

    logic [BASE_BITS-1:0]    raw_base;
    logic [BASE_BITS-1:0]    mag;
    logic [OPERAND_BITS:0]   red_sh;
    logic [OPERAND_BITS:0]   m_ext;
    logic [OPERAND_BITS-1:0] red_next;
    logic                    in_acc;

    t_mm_ctrl                mm_ctrl;
    t_mm_stat                mm_stat;
    logic [OPERAND_BITS-1:0] mm_x;
    logic [OPERAND_BITS-1:0] mm_result;

    // magnitude of the two's complement base
    assign raw_base = s_axis_tdata[BASE_BITS-1:0];
    assign mag      = raw_base[BASE_BITS-1] ? (~raw_base + 1'b1) : raw_base;
    assign in_acc   = s_axis_tvalid && s_axis_tready;

    // one restoring remainder step of the base reduction
    assign m_ext    = {1'b0, r_m};
    assign red_sh   = {r_b, r_mag[r_cnt]};
    assign red_next = (red_sh >= m_ext) ? OPERAND_BITS'(red_sh - m_ext)
                                        : red_sh[OPERAND_BITS-1:0];

    // multiplier launch: product times base on a one bit, else the squaring
    assign mm_ctrl.start = ((r_state == S_BIT) && (r_e != '0)) || (r_state == S_SQ);
    assign mm_x          = ((r_state == S_BIT) && r_e[0]) ? r_prod : r_b;

    mexp_modmul #(
        .OPND_W (OPERAND_BITS)
    ) u_modmul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (mm_ctrl),
        .i_x      (mm_x),
        .i_y      (r_b),
        .i_m      (r_m),
        .o_stat   (mm_stat),
        .o_result (mm_result)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_e         = r_e;
        n_m         = r_m;
        n_b         = r_b;
        n_prod      = r_prod;
        n_mag       = r_mag;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out_power = r_out_power;
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_e   = r_exp_cfg;
                    n_m   = r_mod_cfg;
                    n_mag = mag;
                    n_b   = '0;
                    n_cnt = CNT_W'(BASE_BITS - 1);
                    if (r_mod_cfg < OPERAND_BITS'(2)) begin
                        n_prod  = '0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_RED;
                    end
                end
            end
            S_RED: begin
                n_b   = red_next;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_prod  = OPERAND_BITS'(1);
                    n_state = S_BIT;
                end
            end
            S_BIT: begin
                if (r_e == '0) begin
                    n_state = S_DONE;
                end else if (r_e[0]) begin
                    n_state = S_MULP;
                end else begin
                    n_state = S_MULS;
                end
            end
            S_MULP: begin
                if (mm_stat.done) begin
                    n_prod  = mm_result;
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                n_state = S_MULS;
            end
            S_MULS: begin
                if (mm_stat.done) begin
                    n_b     = mm_result;
                    n_e     = r_e >> 1;
                    n_state = S_BIT;
                end
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_power = r_prod;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state, configuration and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_exp_cfg   <= OPERAND_BITS'(EXPONENT_RESET);
            r_mod_cfg   <= OPERAND_BITS'(MODULUS_RESET);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_EXPONENT: r_exp_cfg <= i_cfg_data;
                    CFG_MODULUS:  r_mod_cfg <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        r_e         <= n_e;
        r_m         <= n_m;
        r_b         <= n_b;
        r_prod      <= n_prod;
        r_mag       <= n_mag;
        r_cnt       <= n_cnt;
        r_out_power <= n_out_power;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'(r_out_power);

endmodule

>>> src/mexp_checker.sv
// port-level checker for the modular exponentiation block, with its bind
module mexp_checker #(
    parameter int OPERAND_BITS = mexp_pkg::OPERAND_BITS_DEF
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_cfg_we,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [mexp_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [mexp_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import mexp_pkg::*;

    // one word at a time: ready drops after an accepted word
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready stayed high after an accepted word");

    // a result only appears after the block was busy
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared while block was idle");

    // idle with no input word produces no new result
    a_no_invented_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tready && !s_axis_tvalid) |=> !$rose(m_axis_tvalid))
        else $error("result produced without an input word");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled output word changed");

    // register writes only while the block is idle and drained
    a_cfg_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |-> (s_axis_tready && !m_axis_tvalid))
        else $error("register written while a word was in flight");

endmodule

bind modular_exponentiation_top mexp_checker #(
    .OPERAND_BITS (OPERAND_BITS)
) u_mexp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_we      (i_cfg_we),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> bench/modular_exponentiation_top_test.sv
// self-checking stream testbench for the modular exponentiation top level
module modular_exponentiation_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mexp_pkg::*;

    localparam int OPND = OPERAND_BITS_DEF;
    localparam logic [61:0] MAX62 = 62'h3FFF_FFFF_FFFF_FFFF;
    localparam int HOLD_CYCLES = 3000;
    localparam int SETTINGS_PER_MODE = 8;
    localparam int WORDS_PER_SETTING = 4;
    localparam int NUM_VECTORS = 21;

    // block ports, all inputs driven from time zero
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = CFG_EXPONENT;
    logic [OPND-1:0]       i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;  // [62:0] base, [63] pad
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;       // [61:0] power, [63:62] zero

    modular_exponentiation_top #(.OPERAND_BITS(OPND)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // directed vector: optional register load, base, and a typed power where obvious
    typedef struct packed {
        logic        load_cfg;
        logic [61:0] exponent;
        logic [61:0] modulus;
        logic [62:0] base;
        logic        known;
        logic [61:0] power;
    } t_vector;

    t_vector vectors [NUM_VECTORS] = '{
        // reset registers: exponent 65537, modulus 2
        '{1'b0, 62'd0, 62'd0, 63'd3, 1'b1, 62'd1},
        '{1'b0, 62'd0, 62'd0, 63'd0, 1'b1, 62'd0},
        '{1'b0, 62'd0, 62'd0, 63'h7FFF_FFFF_FFFF_FFFF, 1'b1, 62'd1},
        '{1'b0, 62'd0, 62'd0, 63'h4000_0000_0000_0000, 1'b1, 62'd0},
        // exponent zero gives one, even for a zero base
        '{1'b1, 62'd0, MAX62, 63'd12345, 1'b1, 62'd1},
        '{1'b0, 62'd0, 62'd0, 63'd0, 1'b1, 62'd1},
        // base extremes against the largest modulus
        '{1'b1, 62'd1, MAX62, 63'h3FFF_FFFF_FFFF_FFFF, 1'b1, 62'd0},
        '{1'b0, 62'd0, 62'd0, 63'h4000_0000_0000_0000, 1'b1, 62'd1},
        '{1'b0, 62'd0, 62'd0, 63'h4000_0000_0000_0001, 1'b1, 62'd0},
        // negative base uses its magnitude
        '{1'b1, 62'd1, 62'd1000, 63'd123456, 1'b1, 62'd456},
        '{1'b0, 62'd0, 62'd0, 63'h7FFF_FFFF_FFFE_1DC0, 1'b1, 62'd456},
        // minus one cubed
        '{1'b1, 62'd3, MAX62, 63'h3FFF_FFFF_FFFF_FFFE, 1'b1, 62'h3FFF_FFFF_FFFF_FFFE},
        // modulus below two gives zero, also with exponent zero
        '{1'b1, 62'd5, 62'd0, 63'd5, 1'b1, 62'd0},
        '{1'b1, 62'd0, 62'd1, 63'd5, 1'b1, 62'd0},
        // smallest legal modulus, then a full-width exponent
        '{1'b1, 62'd5, 62'd2, 63'd7, 1'b1, 62'd1},
        '{1'b1, MAX62, 62'd2, 63'd3, 1'b1, 62'd1},
        '{1'b1, MAX62, 62'h3FFF_FFFF_FFFF_FFC3, 63'h1234_5678_9ABC_DEF0, 1'b0, 62'd0},
        '{1'b0, 62'd0, 62'd0, 63'h7654_3210_FEDC_BA98, 1'b0, 62'd0},
        '{1'b1, 62'd65537, 62'd3233, 63'd65, 1'b0, 62'd0},
        '{1'b0, 62'd0, 62'd0, 63'h4000_0000_0000_0000, 1'b0, 62'd0},
        '{1'b1, 62'd2, 62'h2000_0000_0000_0001, 63'h3FFF_FFFF_FFFF_FFFF, 1'b0, 62'd0}
    };

    // register copies and bookkeeping
    logic [61:0] exponent_reg = 62'd65537;
    logic [61:0] modulus_reg = 62'd2;
    logic [61:0] expected_powers [$];
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_requests = 0;
    int failures = 0;
    int words_sent = 0;
    int words_checked = 0;
    int wide_exp_words = 0;
    int settings_used = 0;

    // (x*y) mod m by shift-add-reduce, x and y already below m
    function automatic logic [63:0] mod_product(logic [63:0] x, logic [63:0] y,
                                                logic [63:0] m);
        logic [63:0] acc;
        acc = '0;
        while (y != 0) begin
            if (y[0]) begin
                acc = acc + x;
                if (acc >= m) acc = acc - m;
            end
            x = x << 1;
            if (x >= m) x = x - m;
            y = y >> 1;
        end
        return acc;
    endfunction

    // |base| ^ exponent mod modulus, right-to-left over the exponent bits
    function automatic logic [61:0] predict_power(logic [62:0] base, logic [61:0] e,
                                                  logic [61:0] m);
        logic [63:0] mag;
        logic [63:0] sq;
        logic [63:0] prod;
        if (m < 62'd2) return '0;
        mag = base[62] ? (64'h8000_0000_0000_0000 - {1'b0, base}) : {1'b0, base};
        sq = mag % {2'b00, m};
        prod = 64'd1;
        while (e != 0) begin
            if (e[0]) prod = mod_product(prod, sq, {2'b00, m});
            sq = mod_product(sq, sq, {2'b00, m});
            e = e >> 1;
        end
        return prod[61:0];
    endfunction

    // random value with exactly k significant bits
    function automatic logic [61:0] rand_width(int k);
        logic [63:0] r;
        r = {$urandom, $urandom};
        if (k == 0) return '0;
        r = r & ((64'd1 << k) - 64'd1);
        r[k-1] = 1'b1;
        return r[61:0];
    endfunction

    task automatic flag_error(input string msg);
        failures++;
        if (failures <= 10) $display("ERROR: %s", msg);
    endtask

    // offer one base word, record its expected power on acceptance
    task automatic send_word(input logic [62:0] base, input logic known,
                             input logic [61:0] power);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, base};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_powers.push_back(known ? power
                                        : predict_power(base, exponent_reg, modulus_reg));
        words_sent++;
    endtask

    // stop offering and wait until every expected power has arrived
    task automatic wait_for_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_powers.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [61:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_EXPONENT) exponent_reg = value;
        else modulus_reg = value;
    endtask

    // registers change only with the block idle
    task automatic load_settings(input logic [61:0] e, input logic [61:0] m);
        wait_for_results();
        write_reg(CFG_EXPONENT, e);
        write_reg(CFG_MODULUS, m);
        settings_used++;
    endtask

    function automatic logic [62:0] rand_base();
        logic [62:0] b;
        case ($urandom_range(7))
            0: begin
                b = {1'b0, rand_width($urandom_range(8))};
                if ($urandom_range(1) == 1) b = -b;
            end
            1: b = 63'h4000_0000_0000_0000;
            default: b = 63'({$urandom, $urandom});
        endcase
        return b;
    endfunction

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // receiver ready: random idling, plus long holds on request
    initial begin
        int hold_left;
        int holds_served;
        hold_left = 0;
        holds_served = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && holds_served != hold_requests) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // output checker against the oldest expected power
    initial begin
        logic [61:0] want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                if (expected_powers.size() == 0) begin
                    flag_error($sformatf("unexpected word, power %h", m_axis_tdata[61:0]));
                end else begin
                    want = expected_powers.pop_front();
                    words_checked++;
                    if (m_axis_tdata[61:0] !== want)
                        flag_error($sformatf("power expected %h got %h",
                                             want, m_axis_tdata[61:0]));
                end
            end
        end
    end

    // run time limit
    initial begin
        #50_000_000;
        $display("simulation failed");
        $finish;
    end

    // stimulus
    initial begin
        logic [61:0] e;
        logic [61:0] m;
        int holding;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed vectors, no idling
        for (int v = 0; v < NUM_VECTORS; v++) begin
            if (vectors[v].load_cfg) load_settings(vectors[v].exponent, vectors[v].modulus);
            if (exponent_reg == MAX62) wide_exp_words++;
            send_word(vectors[v].base, vectors[v].known, vectors[v].power);
        end

        // random settings under three idling patterns
        for (int mode = 0; mode < 3; mode++) begin
            tx_idle_pct = (mode == 0) ? 16 : (mode == 1) ? 80 : 0;
            rx_idle_pct = (mode == 0) ? 80 : (mode == 1) ? 16 : 0;
            for (int s = 0; s < SETTINGS_PER_MODE; s++) begin
                holding = (mode == 1 && s == 0);
                if (!holding && $urandom_range(7) == 0) e = rand_width(62);
                else e = rand_width($urandom_range(holding ? 8 : 12));
                case ($urandom_range(11))
                    0: m = 62'd2;
                    1: m = MAX62;
                    2: m = 62'($urandom_range(1));
                    default: m = rand_width($urandom_range(62, 2));
                endcase
                load_settings(e, m);
                // receiver stalls long enough for the input side to back up
                if (holding) hold_requests++;
                for (int n = 0; n < WORDS_PER_SETTING; n++) begin
                    // sender pause until the block has drained
                    if (n == 2 && !holding && (s == 3 || $urandom_range(3) == 0))
                        wait_for_results();
                    if (e[61]) wide_exp_words++;
                    send_word(rand_base(), 1'b0, '0);
                end
            end
        end

        // drain and watch for stray words
        wait_for_results();
        repeat (200) @(posedge i_clk);
        if (expected_powers.size() != 0) flag_error("expected powers left over");

        $display("covered %0d base words over %0d register settings, %0d with a 62-bit exponent",
                 words_sent, settings_used, wide_exp_words);
        $display("checked %0d powers, %0d mismatches, one long receiver hold",
                 words_checked, failures);
        if (failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
